FILE: hw/rtl/i2ctb_pkg.sv
package i2ctb_pkg;

  // Reset value of the target address
  localparam logic [6:0] DEV_ADDR_RESET = 7'h24;
  // Byte loaded on a read that started with an empty queue
  localparam logic [7:0] JUNK_BYTE      = 8'h7f;
  // Status byte when the queue holds data
  localparam logic [7:0] STATUS_DATA    = 8'h01;

  // Bus phase, also the bus_state output code
  typedef enum logic [3:0] {
    PH_IDLE    = 4'd0,
    PH_ADDR    = 4'd1,
    PH_ACKWR   = 4'd2,
    PH_ACKRD   = 4'd3,
    PH_IGNORE  = 4'd4,
    PH_ACKDATA = 4'd5,
    PH_WRDATA  = 4'd6,
    PH_READ    = 4'd7,
    PH_ACKNACK = 4'd8
  } phase_t;

  // What the transfer does with the transmit queue
  typedef enum logic [1:0] {
    BM_UNKNOWN = 2'd0,
    BM_NOTUSED = 2'd1,
    BM_VALID   = 2'd2,
    BM_INVALID = 2'd3
  } bmode_t;

  // Classified input word
  typedef enum logic [2:0] {
    EV_NONE  = 3'd0,
    EV_START = 3'd1,
    EV_STOP  = 3'd2,
    EV_RISE  = 3'd3,
    EV_FALL  = 3'd4,
    EV_PUSH  = 3'd5
  } evt_kind_t;

  typedef struct packed {
    evt_kind_t   kind;
    logic        sda;
    logic [7:0]  data;
  } evt_t;

  // One result word
  typedef struct packed {
    logic        sda_release;
    logic        rx_valid;
    logic [7:0]  rx_byte;
    logic        rx_clear;
    logic        loaded_valid;
    logic [7:0]  loaded_byte;
    logic [3:0]  bus_state;
    logic [4:0]  tx_count;
    logic        push_dropped;
  } result_t;

endpackage

FILE: hw/rtl/i2ctb_ram.sv
module i2ctb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port (old data on collision)
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hw/rtl/i2ctb_fifo.sv
module i2ctb_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  // DEPTH is a power of two so the pointers wrap on their own
  localparam int AW = $clog2(DEPTH);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [AW:0]      count;
  logic             do_wr;
  logic             do_rd;

  assign full    = (count == (AW+1)'(DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = slots[rd_ptr];

  // Pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= wr_ptr + AW'(1);
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + AW'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + (AW+1)'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - (AW+1)'(1);
      end
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_data;
    end
  end

endmodule

FILE: hw/rtl/i2ctb_front.sv
module i2ctb_front
  import i2ctb_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic       op,
  input  logic       scl_level,
  input  logic       sda_level,
  input  logic [7:0] push_byte,
  output evt_t       evt
);

  // Line history, idle high
  logic prev_scl;
  logic prev_sda;

  // Classify against the previous sample
  always_comb begin
    evt.sda  = sda_level;
    evt.data = push_byte;
    if (op) begin
      evt.kind = EV_PUSH;
    end else if (scl_level && (sda_level != prev_sda)) begin
      evt.kind = sda_level ? EV_STOP : EV_START;
    end else if (scl_level != prev_scl) begin
      evt.kind = scl_level ? EV_RISE : EV_FALL;
    end else begin
      evt.kind = EV_NONE;
    end
  end

  // Pushes leave the history alone
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_scl <= 1'b1;
      prev_sda <= 1'b1;
    end else if (accept && !op) begin
      prev_scl <= scl_level;
      prev_sda <= sda_level;
    end
  end

endmodule

FILE: hw/rtl/i2ctb_engine.sv
module i2ctb_engine
  import i2ctb_pkg::*;
#(
  parameter int TX_DEPTH = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic [6:0] device_address,
  input  logic       evt_valid,
  input  evt_t       evt,
  output logic       evt_take,
  input  logic       res_full,
  output logic       res_push,
  output result_t    res
);

  localparam int AW = $clog2(TX_DEPTH);
  localparam int CW = $clog2(TX_DEPTH + 1);
  localparam int SW = CW + 1;

  // Bus state
  phase_t      phase, phase_next;
  bmode_t      bmode, bmode_next;
  logic [2:0]  bit_index, bit_index_next;
  logic [6:0]  address_shift, address_shift_next;
  logic [7:0]  data_shift, data_shift_next;
  logic        sda_drive, sda_drive_next;

  // Transmit queue control
  logic [AW-1:0] tx_head, tx_head_next;
  logic [CW-1:0] tx_fill, tx_fill_next;
  logic [AW-1:0] head_inc;
  logic [SW-1:0] tail_sum;
  logic [AW-1:0] tail_addr;
  logic          q_we;
  logic [7:0]    head_byte;
  logic [7:0]    ram_rdata;
  logic          byp;
  logic [7:0]    byp_data;

  // Result fields
  logic       rxv, rxc, ldv, drop;
  logic [7:0] rxb, ldb;

  assign evt_take = evt_valid && !res_full;
  assign res_push = evt_take;

  // Queue addressing; sum stays below twice the depth
  assign head_inc = (tx_head == AW'(TX_DEPTH - 1)) ? '0 : tx_head + AW'(1);
  always_comb begin
    tail_sum = SW'(tx_head) + SW'(tx_fill);
    if (tail_sum >= SW'(TX_DEPTH)) begin
      tail_sum = tail_sum - SW'(TX_DEPTH);
    end
  end
  assign tail_addr = AW'(tail_sum);
  assign head_byte = byp ? byp_data : ram_rdata;

  // Read port always tracks the next head
  i2ctb_ram #(
    .WIDTH (8),
    .DEPTH (TX_DEPTH)
  ) u_txq (
    .clk   (clk),
    .we    (q_we),
    .waddr (tail_addr),
    .wdata (evt.data),
    .raddr (tx_head_next),
    .rdata (ram_rdata)
  );

  // Next state and result
  always_comb begin
    phase_next         = phase;
    bmode_next         = bmode;
    bit_index_next     = bit_index;
    address_shift_next = address_shift;
    data_shift_next    = data_shift;
    sda_drive_next     = sda_drive;
    tx_head_next       = tx_head;
    tx_fill_next       = tx_fill;
    q_we               = 1'b0;
    rxv                = 1'b0;
    rxb                = '0;
    rxc                = 1'b0;
    ldv                = 1'b0;
    ldb                = '0;
    drop               = 1'b0;

    if (evt_take) begin
      case (evt.kind)
        EV_PUSH: begin
          if (tx_fill == CW'(TX_DEPTH)) begin
            drop = 1'b1;
          end else begin
            q_we         = 1'b1;
            tx_fill_next = tx_fill + CW'(1);
          end
        end
        EV_START: begin
          phase_next         = PH_ADDR;
          bit_index_next     = 3'd7;
          address_shift_next = '0;
          bmode_next         = BM_UNKNOWN;
        end
        EV_STOP: begin
          if (bmode == BM_VALID) begin
            tx_head_next = '0;
            tx_fill_next = '0;
          end
          phase_next = PH_IDLE;
        end
        EV_RISE: begin
          case (phase)
            PH_ADDR: begin
              if (bit_index != 3'd0) begin
                address_shift_next = {address_shift[5:0], evt.sda};
              end else if (address_shift == device_address && evt.sda) begin
                phase_next = PH_ACKRD;
                bmode_next = (tx_fill == '0) ? BM_INVALID : BM_VALID;
              end else if (address_shift == device_address) begin
                phase_next = PH_ACKWR;
                bmode_next = BM_NOTUSED;
              end else begin
                phase_next = PH_IGNORE;
              end
              bit_index_next = bit_index - 3'd1;
            end
            PH_IGNORE: begin
              phase_next = PH_IDLE;
            end
            PH_ACKRD, PH_ACKWR: begin
              bit_index_next = 3'd7;
              if (bmode == BM_INVALID || bmode == BM_VALID) begin
                data_shift_next = (bmode == BM_VALID) ? STATUS_DATA : 8'h00;
                ldv             = 1'b1;
                ldb             = data_shift_next;
                phase_next      = PH_READ;
              end else begin
                data_shift_next = '0;
                phase_next      = PH_WRDATA;
                rxc             = 1'b1;
              end
            end
            PH_WRDATA: begin
              data_shift_next = {data_shift[6:0], evt.sda};
              if (bit_index == 3'd0) begin
                phase_next = PH_ACKDATA;
              end else begin
                bit_index_next = bit_index - 3'd1;
              end
            end
            PH_ACKDATA: begin
              rxv             = 1'b1;
              rxb             = data_shift;
              data_shift_next = '0;
              bit_index_next  = 3'd7;
              phase_next      = PH_WRDATA;
            end
            PH_ACKNACK: begin
              if (evt.sda) begin
                // NACK ends the read
                phase_next = PH_IDLE;
                if (bmode == BM_VALID) begin
                  tx_head_next = '0;
                  tx_fill_next = '0;
                end
              end else begin
                phase_next     = PH_READ;
                bit_index_next = 3'd7;
                if (bmode == BM_INVALID) begin
                  data_shift_next = JUNK_BYTE;
                end else if (tx_fill == '0) begin
                  data_shift_next = 8'h00;
                end else begin
                  data_shift_next = head_byte;
                  tx_head_next    = head_inc;
                  tx_fill_next    = tx_fill - CW'(1);
                end
                ldv = 1'b1;
                ldb = data_shift_next;
              end
            end
            PH_READ: begin
              if (bit_index == 3'd0) begin
                phase_next = PH_ACKNACK;
              end else begin
                bit_index_next = bit_index - 3'd1;
              end
            end
            default: begin
            end
          endcase
        end
        EV_FALL: begin
          case (phase)
            PH_IGNORE, PH_WRDATA, PH_ACKNACK: begin
              sda_drive_next = 1'b1;
            end
            PH_ACKRD, PH_ACKWR, PH_ACKDATA: begin
              sda_drive_next = 1'b0;
            end
            PH_READ: begin
              sda_drive_next = (bmode == BM_INVALID) ? 1'b0 : data_shift[bit_index];
            end
            default: begin
            end
          endcase
        end
        default: begin
        end
      endcase
    end

    res.sda_release  = sda_drive_next;
    res.rx_valid     = rxv;
    res.rx_byte      = rxb;
    res.rx_clear     = rxc;
    res.loaded_valid = ldv;
    res.loaded_byte  = ldb;
    res.bus_state    = phase_next;
    res.tx_count     = 5'(tx_fill_next);
    res.push_dropped = drop;
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      bmode         <= BM_UNKNOWN;
      bit_index     <= '0;
      address_shift <= '0;
      data_shift    <= '0;
      sda_drive     <= 1'b1;
      tx_head       <= '0;
      tx_fill       <= '0;
      byp           <= 1'b0;
    end else begin
      phase         <= phase_next;
      bmode         <= bmode_next;
      bit_index     <= bit_index_next;
      address_shift <= address_shift_next;
      data_shift    <= data_shift_next;
      sda_drive     <= sda_drive_next;
      tx_head       <= tx_head_next;
      tx_fill       <= tx_fill_next;
      byp           <= q_we && (tail_addr == tx_head_next);
    end
  end

  // Write into the slot being read: forward it
  always_ff @(posedge clk) begin
    byp_data <= evt.data;
  end

endmodule

FILE: hw/rtl/i2c_target_byte_bridge.sv
// I2C target with a 7-bit address. Every input word is either one sample of
// SCL/SDA (op = 0) or a byte pushed into the transmit queue (op = 1); every
// accepted word yields exactly one result word. A new word is taken every
// clock cycle while full is low. Words are classified as they are accepted
// into a two-word event queue; the bus engine takes an event when the result
// queue has room and writes its result into a two-word result queue. full
// rises only when results are not being popped and both small queues fill
// (four words in flight). The transmit queue is a TX_DEPTH x 8 RAM with a
// registered read that always prefetches the head byte, so no clearing pass
// is needed after reset. device_address resets to 0x24 and is written through
// cfg_valid/cfg_ready (always ready); the user must write it only while the
// block is idle, the block itself does not enforce this. sda_release is the
// open-drain drive: 1 leaves the line released, 0 pulls it low.
module i2c_target_byte_bridge
  import i2ctb_pkg::*;
#(
  parameter int TX_DEPTH = 16
) (
  input  logic       clk,
  input  logic       rst,
  // input queue side
  input  logic       push,
  output logic       full,
  input  logic       op,
  input  logic       scl_level,
  input  logic       sda_level,
  input  logic [7:0] push_byte,
  // result queue side
  output logic       empty,
  input  logic       pop,
  output logic       sda_release,
  output logic       rx_valid,
  output logic [7:0] rx_byte,
  output logic       rx_clear,
  output logic       loaded_valid,
  output logic [7:0] loaded_byte,
  output logic [3:0] bus_state,
  output logic [4:0] tx_count,
  output logic       push_dropped,
  // address register write
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [6:0] cfg_data
);

  logic       in_accept;
  evt_t       evt_in;
  evt_t       evt_q;
  logic       evt_empty;
  logic       evt_take;
  logic       res_full;
  logic       res_push;
  result_t    res_word;
  result_t    res_out;
  logic [6:0] device_address;
  logic [$bits(evt_t)-1:0]    evt_rd;
  logic [$bits(result_t)-1:0] res_rd;

  assign in_accept = push && !full;
  assign cfg_ready = 1'b1;

  // Address register
  always_ff @(posedge clk) begin
    if (rst) begin
      device_address <= DEV_ADDR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      device_address <= cfg_data;
    end
  end

  // Front: line history and event classification
  i2ctb_front u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (in_accept),
    .op        (op),
    .scl_level (scl_level),
    .sda_level (sda_level),
    .push_byte (push_byte),
    .evt       (evt_in)
  );

  // Event queue between front and engine
  i2ctb_fifo #(
    .WIDTH ($bits(evt_t)),
    .DEPTH (2)
  ) u_evt_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (push),
    .wr_data (evt_in),
    .full    (full),
    .rd_en   (evt_take),
    .rd_data (evt_rd),
    .empty   (evt_empty)
  );

  assign evt_q = evt_t'(evt_rd);

  // Bus engine and transmit queue
  i2ctb_engine #(
    .TX_DEPTH (TX_DEPTH)
  ) u_engine (
    .clk            (clk),
    .rst            (rst),
    .device_address (device_address),
    .evt_valid      (!evt_empty),
    .evt            (evt_q),
    .evt_take       (evt_take),
    .res_full       (res_full),
    .res_push       (res_push),
    .res            (res_word)
  );

  // Result queue
  i2ctb_fifo #(
    .WIDTH ($bits(result_t)),
    .DEPTH (2)
  ) u_res_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (res_push),
    .wr_data (res_word),
    .full    (res_full),
    .rd_en   (pop),
    .rd_data (res_rd),
    .empty   (empty)
  );

  assign res_out      = result_t'(res_rd);
  assign sda_release  = res_out.sda_release;
  assign rx_valid     = res_out.rx_valid;
  assign rx_byte      = res_out.rx_byte;
  assign rx_clear     = res_out.rx_clear;
  assign loaded_valid = res_out.loaded_valid;
  assign loaded_byte  = res_out.loaded_byte;
  assign bus_state    = res_out.bus_state;
  assign tx_count     = res_out.tx_count;
  assign push_dropped = res_out.push_dropped;

  // A received byte always lands back in the write-data phase
  a_rx_phase: assert property (@(posedge clk) disable iff (rst)
    (!empty && rx_valid) |-> (bus_state == PH_WRDATA))
    else $error("rx_valid outside write data phase");

  // A loaded byte always starts the read phase
  a_ld_phase: assert property (@(posedge clk) disable iff (rst)
    (!empty && loaded_valid) |-> (bus_state == PH_READ))
    else $error("loaded_valid outside read phase");

  // A dropped push only happens on a full queue
  a_drop_full: assert property (@(posedge clk) disable iff (rst)
    (!empty && push_dropped) |-> (tx_count == 5'(TX_DEPTH)))
    else $error("push dropped while queue not full");

  // One word cannot both receive and load a byte
  a_rx_ld_excl: assert property (@(posedge clk) disable iff (rst)
    !empty |-> !(rx_valid && loaded_valid))
    else $error("rx and load in one result");

endmodule

FILE: tb/sv/bridge_model_pkg.sv
package bridge_model_pkg;
  import i2ctb_pkg::*;

  localparam int TXQ_DEPTH = 16;

  // Tracks the target's bus engine and transmit queue. Each accepted input
  // word produces one expected result word, and results are checked in order.
  class bridge_scoreboard;
    logic [6:0] dev_addr;
    logic       last_scl;
    logic       last_sda;
    phase_t     bus_ph;
    logic [2:0] bit_idx;
    logic [6:0] addr_sr;
    logic [7:0] data_sr;
    bmode_t     xfer_mode;
    logic       sda_out;
    logic [7:0] txq [TXQ_DEPTH];
    logic [3:0] txq_head;
    logic [4:0] txq_fill;
    result_t    expected_words [$];
    int         errors;

    function new();
      dev_addr  = DEV_ADDR_RESET;
      last_scl  = 1'b1;
      last_sda  = 1'b1;
      bus_ph    = PH_IDLE;
      bit_idx   = '0;
      addr_sr   = '0;
      data_sr   = '0;
      xfer_mode = BM_UNKNOWN;
      sda_out   = 1'b1;
      txq_head  = '0;
      txq_fill  = '0;
      errors    = 0;
    endfunction

    function void set_address(logic [6:0] a);
      dev_addr = a;
    endfunction

    function int pending();
      return expected_words.size();
    endfunction

    // Advance the bus engine by one accepted word and queue its result
    function void note_word(logic w_op, logic w_scl, logic w_sda, logic [7:0] w_byte);
      result_t r;
      r = '0;
      if (w_op) begin
        // push into the transmit queue, dropped when full
        if (txq_fill >= TXQ_DEPTH) begin
          r.push_dropped = 1'b1;
        end else begin
          txq[4'(txq_head + txq_fill[3:0])] = w_byte;
          txq_fill++;
        end
      end else begin
        if (w_scl && (w_sda != last_sda)) begin
          // SDA moved while SCL high: START or STOP
          if (!w_sda) begin
            bus_ph    = PH_ADDR;
            bit_idx   = 3'd7;
            addr_sr   = '0;
            xfer_mode = BM_UNKNOWN;
          end else begin
            if (xfer_mode == BM_VALID) begin
              txq_head = '0;
              txq_fill = '0;
            end
            bus_ph = PH_IDLE;
          end
        end else if (w_scl && !last_scl) begin
          // rising SCL: sample the line
          case (bus_ph)
            PH_ADDR: begin
              if (bit_idx != 3'd0) begin
                addr_sr = {addr_sr[5:0], w_sda};
              end else if (addr_sr == dev_addr) begin
                if (w_sda) begin
                  bus_ph    = PH_ACKRD;
                  xfer_mode = (txq_fill == 0) ? BM_INVALID : BM_VALID;
                end else begin
                  bus_ph    = PH_ACKWR;
                  xfer_mode = BM_NOTUSED;
                end
              end else begin
                bus_ph = PH_IGNORE;
              end
              bit_idx = bit_idx - 3'd1;
            end
            PH_IGNORE: bus_ph = PH_IDLE;
            PH_ACKRD, PH_ACKWR: begin
              bit_idx = 3'd7;
              if (xfer_mode == BM_INVALID || xfer_mode == BM_VALID) begin
                // read: load the status byte
                data_sr        = (xfer_mode == BM_VALID) ? STATUS_DATA : 8'h00;
                r.loaded_valid = 1'b1;
                r.loaded_byte  = data_sr;
                bus_ph         = PH_READ;
              end else begin
                data_sr    = '0;
                bus_ph     = PH_WRDATA;
                r.rx_clear = 1'b1;
              end
            end
            PH_WRDATA: begin
              data_sr = {data_sr[6:0], w_sda};
              if (bit_idx == 3'd0) bus_ph = PH_ACKDATA;
              else bit_idx = bit_idx - 3'd1;
            end
            PH_ACKDATA: begin
              r.rx_valid = 1'b1;
              r.rx_byte  = data_sr;
              data_sr    = '0;
              bit_idx    = 3'd7;
              bus_ph     = PH_WRDATA;
            end
            PH_ACKNACK: begin
              if (w_sda) begin
                // NACK ends the read; a read with data discards the queue
                bus_ph = PH_IDLE;
                if (xfer_mode == BM_VALID) begin
                  txq_head = '0;
                  txq_fill = '0;
                end
              end else begin
                bus_ph  = PH_READ;
                bit_idx = 3'd7;
                if (xfer_mode == BM_INVALID) begin
                  data_sr = JUNK_BYTE;
                end else if (txq_fill == 0) begin
                  data_sr = 8'h00;
                end else begin
                  data_sr = txq[txq_head];
                  txq_head++;
                  txq_fill--;
                end
                r.loaded_valid = 1'b1;
                r.loaded_byte  = data_sr;
              end
            end
            PH_READ: begin
              if (bit_idx == 3'd0) bus_ph = PH_ACKNACK;
              else bit_idx = bit_idx - 3'd1;
            end
            default: ;
          endcase
        end else if (!w_scl && last_scl) begin
          // falling SCL: update the open-drain drive
          case (bus_ph)
            PH_IGNORE, PH_WRDATA, PH_ACKNACK: sda_out = 1'b1;
            PH_ACKRD, PH_ACKWR, PH_ACKDATA:   sda_out = 1'b0;
            PH_READ: sda_out = (xfer_mode == BM_INVALID) ? 1'b0 : data_sr[bit_idx];
            default: ;
          endcase
        end
        last_scl = w_scl;
        last_sda = w_sda;
      end
      r.sda_release = sda_out;
      r.bus_state   = bus_ph;
      r.tx_count    = txq_fill;
      expected_words.push_back(r);
    endfunction

    function void compare_field(string name, logic [7:0] want_v, logic [7:0] got_v);
      if (got_v !== want_v) begin
        $error("%s: expected %0h, got %0h", name, want_v, got_v);
        errors++;
      end
    endfunction

    // Compare one popped result word against the oldest expectation
    function void check_result(result_t got);
      result_t want;
      if (expected_words.size() == 0) begin
        $error("result word with nothing expected");
        errors++;
        return;
      end
      want = expected_words.pop_front();
      compare_field("sda_release", want.sda_release, got.sda_release);
      compare_field("rx_valid", want.rx_valid, got.rx_valid);
      compare_field("rx_byte", want.rx_byte, got.rx_byte);
      compare_field("rx_clear", want.rx_clear, got.rx_clear);
      compare_field("loaded_valid", want.loaded_valid, got.loaded_valid);
      compare_field("loaded_byte", want.loaded_byte, got.loaded_byte);
      compare_field("bus_state", want.bus_state, got.bus_state);
      compare_field("tx_count", want.tx_count, got.tx_count);
      compare_field("push_dropped", want.push_dropped, got.push_dropped);
    endfunction
  endclass

endpackage

FILE: tb/sv/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import i2ctb_pkg::*;
  import bridge_model_pkg::*;

  localparam int HOLD_CYCLES = 400;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       push = 1'b0;
  logic       full;
  logic       op = 1'b0;
  logic       scl_level = 1'b1;
  logic       sda_level = 1'b1;
  logic [7:0] push_byte = 8'h00;
  logic       empty;
  logic       pop = 1'b0;
  logic       sda_release;
  logic       rx_valid;
  logic [7:0] rx_byte;
  logic       rx_clear;
  logic       loaded_valid;
  logic [7:0] loaded_byte;
  logic [3:0] bus_state;
  logic [4:0] tx_count;
  logic       push_dropped;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [6:0] cfg_data = 7'h00;

  bridge_scoreboard sb;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int push_gap_pct = 0;
  int words_sent = 0;
  int hold_trigger = 0;
  int hold_seen = 0;
  int hold_left = 0;
  bit bus_scl = 1'b1;
  bit bus_sda = 1'b1;
  logic [6:0] cur_addr = DEV_ADDR_RESET;

  i2c_target_byte_bridge #(.TX_DEPTH(TXQ_DEPTH)) uut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Result side: check popped words, random stalls, long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty)
        sb.check_result(result_t'({sda_release, rx_valid, rx_byte, rx_clear, loaded_valid,
                                   loaded_byte, bus_state, tx_count, push_dropped}));
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        pop <= 1'b0;
      end else if (hold_seen != hold_trigger) begin
        hold_seen <= hold_trigger;
        hold_left <= HOLD_CYCLES;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Offer one input word, with random idle cycles ahead of it
  task automatic send_word(bit w_op, bit w_scl, bit w_sda, logic [7:0] w_byte);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push      <= 1'b1;
    op        <= w_op;
    scl_level <= w_scl;
    sda_level <= w_sda;
    push_byte <= w_byte;
    @(posedge clk);
    while (full) @(posedge clk);
    sb.note_word(w_op, w_scl, w_sda, w_byte);
    words_sent++;
  endtask

  task automatic push_tx(logic [7:0] b);
    send_word(1'b1, 1'($urandom), 1'($urandom), b);
  endtask

  // One line sample; now and then a queue push slips in ahead of it
  task automatic line(bit l_scl, bit l_sda);
    if ($urandom_range(99) < push_gap_pct) push_tx(8'($urandom));
    send_word(1'b0, l_scl, l_sda, 8'($urandom));
    bus_scl = l_scl;
    bus_sda = l_sda;
  endtask

  task automatic bus_start();
    if (bus_scl && !bus_sda) line(1'b0, 1'b0);
    if (!bus_scl) begin
      line(1'b0, 1'b1);
      line(1'b1, 1'b1);
    end
    line(1'b1, 1'b0);
    line(1'b0, 1'b0);
  endtask

  task automatic bus_stop();
    if (bus_scl) line(1'b0, bus_sda);
    line(1'b0, 1'b0);
    line(1'b1, 1'b0);
    line(1'b1, 1'b1);
  endtask

  // One SCL pulse; SDA only moves while SCL is low
  task automatic bus_bit(bit b);
    if (bus_scl) line(1'b0, bus_sda);
    line(1'b0, b);
    line(1'b1, b);
    line(1'b0, b);
  endtask

  task automatic bus_byte(logic [7:0] b);
    for (int i = 7; i >= 0; i--) bus_bit(b[i]);
  endtask

  // Mostly well-formed transfers with random content, plus noise and cut-off ones
  task automatic random_transfer();
    int pick;
    int nbytes;
    logic [6:0] target;
    bit rd;
    pick = $urandom_range(99);
    if ($urandom_range(99) < 25) repeat ($urandom_range(1, 20)) push_tx(8'($urandom));
    if (pick < 8) begin
      repeat ($urandom_range(1, 6)) line(1'($urandom), 1'($urandom));
    end else if (pick < 15) begin
      // transfer cut short by a STOP or by the next START
      bus_start();
      repeat ($urandom_range(1, 12)) bus_bit(1'($urandom));
      if ($urandom_range(1) == 1) bus_stop();
    end else begin
      target = ($urandom_range(99) < 85) ? cur_addr : 7'($urandom);
      rd     = 1'($urandom);
      nbytes = $urandom_range(0, 4);
      bus_start();
      bus_byte({target, rd});
      bus_bit(1'($urandom));
      if (!rd) begin
        repeat (nbytes) begin
          bus_byte(8'($urandom));
          bus_bit(1'($urandom));
        end
      end else begin
        // status byte, then ACK and another byte per loop
        bus_byte(8'($urandom));
        repeat (nbytes) begin
          bus_bit(1'b0);
          bus_byte(8'($urandom));
        end
        if ($urandom_range(99) < 80) bus_bit(1'b1);
      end
      if ($urandom_range(99) < 80) bus_stop();
    end
  endtask

  // Hold the sender until every expected word is back, then let the pipe settle
  task automatic drain();
    push <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_address(logic [6:0] a);
    cfg_valid <= 1'b1;
    cfg_data  <= a;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    sb.set_address(a);
    cur_addr = a;
  endtask

  initial begin
    sb = new();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed: idle edges, simultaneous line changes, START/STOP, push extremes
    line(1'b1, 1'b1);
    line(1'b0, 1'b1);
    line(1'b1, 1'b1);
    line(1'b0, 1'b0);
    line(1'b1, 1'b1);
    line(1'b0, 1'b1);
    line(1'b1, 1'b0);
    line(1'b0, 1'b0);
    line(1'b1, 1'b0);
    line(1'b1, 1'b1);
    push_tx(8'h00);
    push_tx(8'hff);
    push_tx(8'h5a);
    drain();

    // Sender idles lightly, receiver heavily
    write_address(7'h7f);
    send_idle_pct = 19;
    recv_idle_pct = 79;
    push_gap_pct  = 4;
    while (words_sent < 620) random_transfer();
    bus_stop();
    drain();

    // Sender idles heavily, receiver lightly
    write_address(7'h00);
    send_idle_pct = 79;
    recv_idle_pct = 19;
    while (words_sent < 1240) random_transfer();
    bus_stop();
    drain();

    // No idling; receiver holds off at the start so the block backs up
    write_address(7'($urandom));
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_trigger++;
    while (words_sent < 1850) random_transfer();
    bus_stop();
    drain();

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("i2c_target_byte_bridge regression: pass");
    end else begin
      $display("i2c_target_byte_bridge regression: fail");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(5_000_000);
    $display("i2c_target_byte_bridge regression: fail");
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/i2ctb_pkg.sv
hw/rtl/i2ctb_ram.sv
hw/rtl/i2ctb_fifo.sv
hw/rtl/i2ctb_front.sv
hw/rtl/i2ctb_engine.sv
hw/rtl/i2c_target_byte_bridge.sv
tb/sv/bridge_model_pkg.sv
tb/sv/tb.sv
